[src/csv_pkg.sv]
// Shared constants for the 3x3 Cramer solver.
package csv_pkg;

    localparam int COEF_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int SOL_W          = 32;
    localparam int EPS_W          = 32;
    localparam logic [EPS_W-1:0] EPS_RESET = 32'd1;
    localparam int QUEUE_DEPTH    = 4;
    // quotient bits kept by the divider: result width plus one for the rail checks
    localparam int Q_BITS         = SOL_W + 1;

endpackage

[src/csv_if.sv]
// Channel interfaces: request items, result items and the epsilon write port.
interface csv_item_if #(parameter int COEF_WIDTH = csv_pkg::COEF_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [COEF_WIDTH-1:0] rhs0, rhs1, rhs2;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                     rhs0, rhs1, rhs2, input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                     rhs0, rhs1, rhs2, output ready);
endinterface

interface csv_result_if;
    logic                            valid;
    logic                            ready;
    logic signed [csv_pkg::SOL_W-1:0] sol0, sol1, sol2;
    logic                            solvable;
    logic                            saturated;

    modport source (output valid, sol0, sol1, sol2, solvable, saturated, input ready);
    modport sink   (input valid, sol0, sol1, sol2, solvable, saturated, output ready);
endinterface

interface csv_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [csv_pkg::EPS_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[src/csv_det.sv]
// Pipelined exact 3x3 determinant, five register stages.
module csv_det #(
    parameter int CW = csv_pkg::COEF_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [CW-1:0]   c [9],
    output logic signed [3*CW+2:0] det
);
    localparam int PW = 3 * CW;
    localparam int DW = 3 * CW + 3;
    // first three terms are added, last three subtracted
    localparam int IA [6] = '{0, 1, 2, 0, 1, 2};
    localparam int IB [6] = '{4, 5, 3, 5, 3, 4};
    localparam int IC [6] = '{8, 6, 7, 7, 8, 6};

    logic signed [2*CW-1:0] ab_reg [6];
    logic signed [CW-1:0]   c_reg  [6];
    logic signed [2*CW-1:0] hc_reg [6];
    logic signed [2*CW:0]   lc_reg [6];
    logic signed [PW-1:0]   tr_reg [6];
    logic signed [DW-1:0]   pr_reg [3];
    logic signed [DW-1:0]   det_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < 6; t++)
            begin
                ab_reg[t] <= c[IA[t]] * c[IB[t]];
                c_reg[t]  <= c[IC[t]];
                // split the wide product to keep each multiplier narrow
                hc_reg[t] <= $signed(ab_reg[t][2*CW-1:CW]) * c_reg[t];
                lc_reg[t] <= $signed({1'b0, ab_reg[t][CW-1:0]}) * c_reg[t];
                tr_reg[t] <= (PW'(hc_reg[t]) <<< CW) + PW'(lc_reg[t]);
            end
            for (int j = 0; j < 3; j++)
            begin
                pr_reg[j] <= DW'(tr_reg[j]) - DW'(tr_reg[j+3]);
            end
            det_reg <= pr_reg[0] + pr_reg[1] + pr_reg[2];
        end
    end

    assign det = det_reg;

endmodule

[src/csv_front.sv]
// Front end: capture request, form D and the three numerators, classify singularity.
module csv_front #(
    parameter int CW = csv_pkg::COEF_WIDTH_DEF,
    parameter int F  = csv_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [CW-1:0]        m [9],
    input  logic signed [CW-1:0]        r [3],
    input  logic [csv_pkg::EPS_W-1:0]   eps,
    output logic                        push,
    output logic signed [3*CW+2:0]      d,
    output logic signed [3*CW+2:0]      n [3],
    output logic                        solv
);
    localparam int DW   = 3 * CW + 3;
    localparam int TW   = csv_pkg::EPS_W + 2 * F;
    localparam int CMPW = (DW > TW) ? DW : TW;
    localparam int NV   = 7;

    logic [NV-1:0]          v_reg;
    logic signed [CW-1:0]   m_reg [9];
    logic signed [CW-1:0]   r_reg [3];
    logic signed [DW-1:0]   dets [4];
    logic signed [DW-1:0]   d_reg;
    logic signed [DW-1:0]   n_reg [3];
    logic                   solv_reg;
    logic [DW-1:0]          dmag;
    logic                   solv_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NV-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= m;
            r_reg    <= r;
            d_reg    <= dets[0];
            n_reg[0] <= dets[1];
            n_reg[1] <= dets[2];
            n_reg[2] <= dets[3];
            solv_reg <= solv_next;
        end
    end

    // det 0 is D, det k replaces column k-1 with the right-hand vector
    for (genvar k = 0; k < 4; k++)
    begin : g_det
        logic signed [CW-1:0] w [9];
        for (genvar i = 0; i < 9; i++)
        begin : g_w
            if (k > 0 && (i % 3) == k - 1)
            begin : g_rhs
                assign w[i] = r_reg[i / 3];
            end
            else
            begin : g_mat
                assign w[i] = m_reg[i];
            end
        end
        csv_det #(.CW(CW)) u_det (
            .clk (clk),
            .en  (en),
            .c   (w),
            .det (dets[k])
        );
    end

    always_comb
    begin
        dmag      = dets[0][DW-1] ? DW'(-dets[0]) : DW'(dets[0]);
        solv_next = (dmag != '0) && (CMPW'(dmag) >= (CMPW'(eps) << (2 * F)));
    end

    assign push = en && v_reg[NV-1];
    assign d    = d_reg;
    assign n    = n_reg;
    assign solv = solv_reg;

endmodule

[src/csv_queue.sv]
// Small FIFO between front and back ends.
module csv_queue #(
    parameter int W     = 8,
    parameter int DEPTH = csv_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic         pop,
    input  logic [W-1:0] wdata,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) push |-> !full;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_no_underflow;
        @(posedge clk) disable iff (!rst_n) pop |-> !empty;
    endproperty
    a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

endmodule

[src/csv_back.sv]
// Back end: pipelined rounding division for three unknowns, saturation, output register.
module csv_back #(
    parameter int CW = csv_pkg::COEF_WIDTH_DEF,
    parameter int F  = csv_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [3*CW+2:0]            d,
    input  logic signed [3*CW+2:0]            n [3],
    input  logic                              solv,
    output logic                              take,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [csv_pkg::SOL_W-1:0]  sol [3],
    output logic                              solvable,
    output logic                              saturated
);
    localparam int DW  = 3 * CW + 3;
    localparam int QB  = csv_pkg::Q_BITS;
    localparam int SW  = csv_pkg::SOL_W;
    localparam int XW  = DW + F + 2;
    localparam int DVW = DW + 1;
    localparam int RW  = DW + 2;
    localparam logic [QB-1:0] POS_LIM = QB'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic [QB-1:0] NEG_LIM = QB'(64'd1 << (SW - 1));

    logic             v_reg    [QB+1];
    logic             solv_reg [QB+1];
    logic [DVW-1:0]   dv_reg   [QB+1];
    logic [RW-1:0]    r_reg    [QB+1][3];
    logic [QB-1:0]    x_reg    [QB+1][3];
    logic [QB-1:0]    q_reg    [QB+1][3];
    logic             neg_reg  [QB+1][3];
    logic             ovf_reg  [QB+1][3];

    logic             out_valid_reg;
    logic signed [SW-1:0] sol_reg [3];
    logic             solvable_reg;
    logic             saturated_reg;

    logic [DW-1:0]    dmag;
    logic [DVW-1:0]   dv0;
    logic [RW-1:0]    r0   [3];
    logic [QB-1:0]    x0   [3];
    logic             neg0 [3];
    logic             ovf0 [3];

    logic signed [SW-1:0] sol_next [3];
    logic             sat_next;

    assign take = !out_valid_reg || out_ready;

    // operand prep: magnitudes, doubled divisor, dividend 2N*2^F + D
    always_comb
    begin
        logic [DW-1:0] nm;
        logic [XW-1:0] xv;
        logic [XW-1:0] xh;
        dmag = d[DW-1] ? DW'(-d) : DW'(d);
        dv0  = DVW'(dmag) << 1;
        for (int k = 0; k < 3; k++)
        begin
            nm      = n[k][DW-1] ? DW'(-n[k]) : DW'(n[k]);
            xv      = (XW'(nm) << (F + 1)) + XW'(dmag);
            xh      = xv >> QB;
            ovf0[k] = xh >= XW'(dv0);
            r0[k]   = xh[RW-1:0];
            x0[k]   = xv[QB-1:0];
            neg0[k] = n[k][DW-1] ^ d[DW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QB; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= QB; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            out_valid_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            solv_reg[0] <= solv;
            dv_reg[0]   <= dv0;
            for (int k = 0; k < 3; k++)
            begin
                r_reg[0][k]   <= r0[k];
                x_reg[0][k]   <= x0[k];
                q_reg[0][k]   <= '0;
                neg_reg[0][k] <= neg0[k];
                ovf_reg[0][k] <= ovf0[k];
            end
            sol_reg       <= sol_next;
            solvable_reg  <= solv_reg[QB];
            saturated_reg <= sat_next;
        end
    end

    // one restoring-division step per stage
    for (genvar s = 0; s < QB; s++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            logic [RW-1:0] t;
            logic          qb;
            if (take)
            begin
                solv_reg[s+1] <= solv_reg[s];
                dv_reg[s+1]   <= dv_reg[s];
                for (int k = 0; k < 3; k++)
                begin
                    t  = {r_reg[s][k][RW-2:0], x_reg[s][k][QB-1]};
                    qb = t >= RW'(dv_reg[s]);
                    r_reg[s+1][k]   <= qb ? t - RW'(dv_reg[s]) : t;
                    x_reg[s+1][k]   <= x_reg[s][k] << 1;
                    q_reg[s+1][k]   <= {q_reg[s][k][QB-2:0], qb};
                    neg_reg[s+1][k] <= neg_reg[s][k];
                    ovf_reg[s+1][k] <= ovf_reg[s][k];
                end
            end
        end
    end

    // clip to the signed rails and apply the sign; an unsolvable item gives zeros
    always_comb
    begin
        logic [QB-1:0] qq;
        logic [QB-1:0] lim;
        logic [QB-1:0] val;
        logic          is_neg;
        logic          sat_k;
        sat_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            qq     = q_reg[QB][k];
            is_neg = neg_reg[QB][k] && (ovf_reg[QB][k] || qq != '0);
            lim    = is_neg ? NEG_LIM : POS_LIM;
            sat_k  = ovf_reg[QB][k] || (qq > lim);
            val    = sat_k ? lim : qq;
            if (!solv_reg[QB])
            begin
                sol_next[k] = '0;
            end
            else
            begin
                sol_next[k] = is_neg ? SW'(-val) : SW'(val);
            end
            sat_next = sat_next || (sat_k && solv_reg[QB]);
        end
    end

    assign out_valid = out_valid_reg;
    assign sol       = sol_reg;
    assign solvable  = solvable_reg;
    assign saturated = saturated_reg;

endmodule

[src/cramer_solve_3x3_core.sv]
// Path of a request: capture register, then the front pipeline, the queue, the divider prep
//   register, the 33 quotient stages and the output register, in that order.
// Throughput: one request per cycle while the queue is not full; the divider pipeline and
//   the output register advance together, so a stalled result stalls only the back end.
// The 4-entry queue lets the front end keep taking requests while the back end stalls.
// Reset: clears all valid bits and the queue; epsilon returns to 1.
module cramer_solve_3x3_core #(
    parameter int COEF_WIDTH = csv_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = csv_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    csv_item_if.sink            item,
    csv_result_if.source        result,
    csv_cfg_if.sink             cfg
);
    localparam int DW = 3 * COEF_WIDTH + 3;
    localparam int QW = 4 * DW + 1;

    logic [csv_pkg::EPS_W-1:0]      epsilon_reg;
    logic signed [COEF_WIDTH-1:0]   m [9];
    logic signed [COEF_WIDTH-1:0]   r [3];
    logic                           front_en;
    logic                           push;
    logic signed [DW-1:0]           f_d;
    logic signed [DW-1:0]           f_n [3];
    logic                           f_solv;
    logic [QW-1:0]                  q_wdata, q_rdata;
    logic                           q_full, q_empty;
    logic                           take, pop;
    logic signed [DW-1:0]           b_d;
    logic signed [DW-1:0]           b_n [3];
    logic                           b_solv;
    logic signed [csv_pkg::SOL_W-1:0] sol [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= csv_pkg::EPS_RESET;
        end
        else if (cfg.valid)
        begin
            epsilon_reg <= cfg.data;
        end
    end
    assign cfg.ready = 1'b1;

    assign m = '{item.m00, item.m01, item.m02, item.m10, item.m11, item.m12,
                 item.m20, item.m21, item.m22};
    assign r = '{item.rhs0, item.rhs1, item.rhs2};

    // front stalls as a whole while the queue is full
    assign front_en   = !q_full;
    assign item.ready = front_en;

    csv_front #(.CW(COEF_WIDTH), .F(FRAC_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (front_en),
        .in_valid (item.valid),
        .m        (m),
        .r        (r),
        .eps      (epsilon_reg),
        .push     (push),
        .d        (f_d),
        .n        (f_n),
        .solv     (f_solv)
    );

    assign q_wdata = {f_solv, f_n[2], f_n[1], f_n[0], f_d};

    csv_queue #(.W(QW), .DEPTH(csv_pkg::QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .wdata (q_wdata),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign pop    = take && !q_empty;
    assign b_d    = q_rdata[DW-1:0];
    assign b_n[0] = q_rdata[2*DW-1:DW];
    assign b_n[1] = q_rdata[3*DW-1:2*DW];
    assign b_n[2] = q_rdata[4*DW-1:3*DW];
    assign b_solv = q_rdata[QW-1];

    csv_back #(.CW(COEF_WIDTH), .F(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop),
        .d         (b_d),
        .n         (b_n),
        .solv      (b_solv),
        .take      (take),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sol       (sol),
        .solvable  (result.solvable),
        .saturated (result.saturated)
    );

    assign result.sol0 = sol[0];
    assign result.sol1 = sol[1];
    assign result.sol2 = sol[2];

    property p_unsolvable_zero;
        @(posedge clk) disable iff (!rst_n)
            result.valid && !result.solvable |->
                result.sol0 == '0 && result.sol1 == '0 && result.sol2 == '0 &&
                !result.saturated;
    endproperty
    a_unsolvable_zero: assert property (p_unsolvable_zero)
        else $error("unsolvable result carries nonzero fields");

    property p_sat_on_rail;
        @(posedge clk) disable iff (!rst_n)
            result.valid && result.saturated |->
                result.sol0 == 32'sh7FFFFFFF || result.sol0 == 32'sh80000000 ||
                result.sol1 == 32'sh7FFFFFFF || result.sol1 == 32'sh80000000 ||
                result.sol2 == 32'sh7FFFFFFF || result.sol2 == 32'sh80000000;
    endproperty
    a_sat_on_rail: assert property (p_sat_on_rail)
        else $error("saturated flag without a clipped unknown");

    property p_stall_only_full;
        @(posedge clk) disable iff (!rst_n)
            push && !pop |=> !q_empty;
    endproperty
    a_stall_only_full: assert property (p_stall_only_full)
        else $error("queue lost a request");

endmodule
